/* rtl/skt_pkg.sv */
// Shared types and codes for the sorted key table.
package skt_pkg;

  localparam int KEY_W    = 56;
  localparam int REQ_W    = 2;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 6;
  localparam int COUNT_W  = 7;

  typedef logic [REQ_W-1:0]    req_type_t;
  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [POS_W-1:0]    pos_t;
  typedef logic [COUNT_W-1:0]  count_t;

  localparam req_type_t REQ_INSERT = 2'd0;
  localparam req_type_t REQ_SEARCH = 2'd1;
  localparam req_type_t REQ_DELETE = 2'd2;

  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_ABSENT = 2'd1;
  localparam status_t ST_DUP    = 2'd2;
  localparam status_t ST_FULL   = 2'd3;

endpackage

/* rtl/skt_if.sv */
// Request and response channel interfaces of the sorted key table.
interface skt_req_if;
  logic                valid;
  logic                ready;
  skt_pkg::req_type_t  req_type;
  skt_pkg::key_t       key;

  modport source (output valid, output req_type, output key, input ready);
  modport sink (input valid, input req_type, input key, output ready);
endinterface

interface skt_rsp_if;
  logic              valid;
  logic              ready;
  skt_pkg::status_t  status;
  skt_pkg::pos_t     position;
  skt_pkg::count_t   entry_count;

  modport source (output valid, output status, output position, output entry_count,
                  input ready);
  modport sink (input valid, input status, input position, input entry_count,
                output ready);
endinterface

/* rtl/skt_key_ram.sv */
// Key storage: one write port and one registered read port.
module skt_key_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 56,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/sorted_key_table.sv */
// Sorted key table: insert, search and delete of unique keys kept in ascending order.
//
// A request transaction on req carries req_type and key; one response transaction
// on rsp carries status, position and entry_count for every request.
// The keys live in a single-port-read, single-port-write RAM with a registered read.
// A request scans the RAM from slot 0 upward, one entry a cycle, until it meets
// the key, a larger key or the last entry. An insert then moves the larger
// entries up one slot a cycle from the top; a delete moves them down one slot a
// cycle. Scan and move share the RAM read port.
// One request is handled at a time; req.ready is high only between requests.
// The response sits in an output register, so a new request is accepted while
// an earlier response still waits; a stalled rsp holds that response and the
// next request waits in its final cycle until the register is free.
// Reset empties the table at once; the RAM contents need no clearing.
module sorted_key_table #(
  parameter int TABLE_DEPTH = 64,
  parameter int KEY_BYTES   = 7
) (
  input  logic        clk,
  input  logic        rst,
  skt_req_if.sink     req,
  skt_rsp_if.source   rsp
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int KW = (8 * KEY_BYTES < skt_pkg::KEY_W) ? 8 * KEY_BYTES : skt_pkg::KEY_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_SHUP = 3'd2;
  localparam logic [2:0] S_INS  = 3'd3;
  localparam logic [2:0] S_SHDN = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]          state;
  skt_pkg::req_type_t  req_type_q;
  logic [KW-1:0]       key_q;
  logic [CW-1:0]       count;
  logic [AW-1:0]       cmp;
  logic [AW-1:0]       slot;
  logic [AW-1:0]       wp;
  skt_pkg::status_t    res_status;

  logic                out_valid;
  skt_pkg::status_t    out_status;
  skt_pkg::pos_t       out_pos;
  skt_pkg::count_t     out_count;

  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic [KW-1:0]       rd_data;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [KW-1:0]       wr_data;

  logic                hit;
  logic                above;
  logic                last;
  logic                stop;
  logic [AW-1:0]       miss_slot;
  logic [AW-1:0]       wp_dn;

  skt_key_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (KW),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.position    = out_pos;
  assign rsp.entry_count = out_count;

  assign hit       = (rd_data == key_q);
  assign above     = (rd_data > key_q);
  assign last      = (CW'(cmp) == count - CW'(1));
  assign stop      = hit || above || last;
  assign miss_slot = above ? cmp : AW'(cmp + 1'b1);
  assign wp_dn     = wp - 1'b1;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = wp;
    wr_data = rd_data;
    unique case (state)
      S_IDLE: begin
        rd_en = req.valid;
      end
      S_SCAN: begin
        rd_en   = 1'b1;
        rd_addr = (stop && req_type_q == skt_pkg::REQ_INSERT) ?
                  AW'(count - CW'(1)) : AW'(cmp + 1'b1);
      end
      S_SHUP: begin
        wr_en   = 1'b1;
        rd_en   = 1'b1;
        rd_addr = wp - 1'b1 - 1'b1;
      end
      S_INS: begin
        wr_en   = 1'b1;
        wr_addr = slot;
        wr_data = key_q;
      end
      S_SHDN: begin
        wr_en   = 1'b1;
        rd_en   = 1'b1;
        rd_addr = wp + 1'b1 + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            req_type_q <= req.req_type;
            key_q      <= req.key[KW-1:0];
            cmp        <= '0;
            slot       <= '0;
            wp         <= '0;
            priority if (req.req_type != skt_pkg::REQ_INSERT &&
                         req.req_type != skt_pkg::REQ_SEARCH &&
                         req.req_type != skt_pkg::REQ_DELETE) begin
              res_status <= skt_pkg::ST_ABSENT;
              state      <= S_DONE;
            end else if (req.req_type == skt_pkg::REQ_INSERT && count == DEPTH_C) begin
              res_status <= skt_pkg::ST_FULL;
              state      <= S_DONE;
            end else if (count == '0) begin
              if (req.req_type == skt_pkg::REQ_INSERT) begin
                state <= S_INS;
              end else begin
                res_status <= skt_pkg::ST_ABSENT;
                state      <= S_DONE;
              end
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (!stop) begin
            cmp <= cmp + 1'b1;
          end else begin
            unique case (req_type_q)
              skt_pkg::REQ_INSERT: begin
                if (hit) begin
                  res_status <= skt_pkg::ST_DUP;
                  slot       <= '0;
                  state      <= S_DONE;
                end else begin
                  slot <= miss_slot;
                  wp   <= AW'(count);
                  if (CW'(miss_slot) == count) begin
                    state <= S_INS;
                  end else begin
                    state <= S_SHUP;
                  end
                end
              end
              skt_pkg::REQ_DELETE: begin
                if (hit) begin
                  res_status <= skt_pkg::ST_OK;
                  slot       <= cmp;
                  wp         <= cmp;
                  count      <= count - CW'(1);
                  if (last) begin
                    state <= S_DONE;
                  end else begin
                    state <= S_SHDN;
                  end
                end else begin
                  res_status <= skt_pkg::ST_ABSENT;
                  slot       <= '0;
                  state      <= S_DONE;
                end
              end
              default: begin
                res_status <= hit ? skt_pkg::ST_OK : skt_pkg::ST_ABSENT;
                slot       <= hit ? cmp : '0;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_SHUP: begin
          wp <= wp_dn;
          if (wp_dn == slot) begin
            state <= S_INS;
          end
        end
        S_INS: begin
          count      <= count + CW'(1);
          res_status <= skt_pkg::ST_OK;
          state      <= S_DONE;
        end
        S_SHDN: begin
          if (CW'(wp) == count - CW'(1)) begin
            state <= S_DONE;
          end else begin
            wp <= wp + 1'b1;
          end
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_pos    <= skt_pkg::POS_W'(slot);
            out_count  <= skt_pkg::COUNT_W'(count);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("Entry count exceeds the table depth.");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && count != $past(count)) |->
      (count == $past(count) + CW'(1) || count == $past(count) - CW'(1)))
    else $error("Entry count moved by more than one.");

  a_resp_from_done: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $rose(out_valid)) |-> $past(state) == S_DONE)
    else $error("Response raised outside the completion state.");

  a_shift_above_slot: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHUP) |-> (wp != slot))
    else $error("Upward move reached the insertion slot.");

endmodule

/* tb/sorted_key_table_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the sorted key table, with directed and random requests.
module sorted_key_table_tb;

  localparam int TABLE_DEPTH = 64;
  localparam int KEY_BYTES = 7;
  localparam int POOL_SIZE = 96;
  localparam int RANDOM_ITEMS = 430;
  localparam int MAX_GAP = 18;
  localparam int LONG_HOLD = 400;
  localparam int SETTLE_CYCLES = 4 * (TABLE_DEPTH + 4);
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;
  localparam skt_pkg::req_type_t REQ_UNUSED = 2'd3;

  typedef struct {
    skt_pkg::req_type_t rq;
    skt_pkg::key_t      key;
    bit                 drain_first;
  } req_item_t;

  typedef struct {
    skt_pkg::status_t status;
    skt_pkg::pos_t    position;
    skt_pkg::count_t  entry_count;
  } rsp_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  skt_req_if req_ch();
  skt_rsp_if rsp_ch();

  sorted_key_table #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .KEY_BYTES(KEY_BYTES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always #5 clk = ~clk;

  skt_pkg::key_t held_keys [TABLE_DEPTH];
  int            held_count = 0;
  req_item_t     pending_req [$];
  rsp_item_t     pending_rsp [$];
  skt_pkg::key_t key_pool [POOL_SIZE];
  req_item_t     cur_req;
  rsp_item_t     want;
  bit            req_in_flight = 1'b0;
  int            send_wait = 0;
  bit            send_burst = 1'b0;
  int            send_gap;
  int            recv_wait = 0;
  bit            recv_burst = 1'b0;
  int            recv_gap;
  int            rsp_seen = 0;
  int            errors = 0;
  int            long_holds = 0;
  int            sender_pauses = 0;
  int            cycle_cnt = 0;
  int            req_seen [4] = '{0, 0, 0, 0};
  int            status_seen [4] = '{0, 0, 0, 0};

  function automatic rsp_item_t apply_request(skt_pkg::req_type_t rq, skt_pkg::key_t k);
    rsp_item_t r;
    int slot;
    int i;
    r.status = skt_pkg::ST_ABSENT;
    r.position = '0;
    slot = -1;
    for (i = 0; i < held_count; i++) begin
      if (held_keys[i] == k) slot = i;
    end
    case (rq)
      skt_pkg::REQ_INSERT: begin
        if (held_count >= TABLE_DEPTH) begin
          r.status = skt_pkg::ST_FULL;
        end else if (slot >= 0) begin
          r.status = skt_pkg::ST_DUP;
        end else begin
          i = held_count;
          while (i > 0 && k < held_keys[i-1]) begin
            held_keys[i] = held_keys[i-1];
            i--;
          end
          held_keys[i] = k;
          held_count++;
          r.status = skt_pkg::ST_OK;
          r.position = skt_pkg::pos_t'(i);
        end
      end
      skt_pkg::REQ_SEARCH: begin
        if (slot >= 0) begin
          r.status = skt_pkg::ST_OK;
          r.position = skt_pkg::pos_t'(slot);
        end
      end
      skt_pkg::REQ_DELETE: begin
        if (slot >= 0) begin
          for (i = slot; i + 1 < held_count; i++) held_keys[i] = held_keys[i+1];
          held_count--;
          r.status = skt_pkg::ST_OK;
          r.position = skt_pkg::pos_t'(slot);
        end
      end
      default: ;
    endcase
    r.entry_count = skt_pkg::count_t'(held_count);
    return r;
  endfunction

  function automatic int draw_gap(bit burst);
    return burst ? 0 : int'($urandom_range(0, MAX_GAP));
  endfunction

  function automatic skt_pkg::key_t random_key();
    return skt_pkg::key_t'({$urandom, $urandom});
  endfunction

  function automatic skt_pkg::key_t name_key();
    skt_pkg::key_t k;
    int len;
    int b;
    k = '0;
    len = $urandom_range(1, KEY_BYTES);
    for (b = 0; b < len; b++)
      k[skt_pkg::KEY_W-1-8*b -: 8] = 8'h41 + 8'($urandom_range(0, 25));
    return k;
  endfunction

  task automatic queue_req(skt_pkg::req_type_t rq, skt_pkg::key_t k, bit drain_first = 1'b0);
    req_item_t it;
    it.rq = rq;
    it.key = k;
    it.drain_first = drain_first;
    pending_req.push_back(it);
  endtask

  task automatic build_stimulus();
    skt_pkg::key_t k_alpha;
    skt_pkg::key_t k_mango;
    skt_pkg::key_t k_b;
    skt_pkg::key_t k_zeds;
    skt_pkg::key_t k_tmp;
    skt_pkg::key_t flip;
    bit   used [skt_pkg::key_t];
    int   i;
    int   j;
    int   mode;
    int   len;
    int   r;
    int   made;
    skt_pkg::req_type_t rq;
    k_alpha = {"ALPHA", 16'h0000};
    k_mango = {"MANGO", 16'h0000};
    k_b     = {"B", 48'h0};
    k_zeds  = "ZZZZZZZ";

    queue_req(skt_pkg::REQ_SEARCH, k_alpha);
    queue_req(skt_pkg::REQ_DELETE, k_alpha);
    queue_req(REQ_UNUSED, '0);
    queue_req(skt_pkg::REQ_INSERT, k_mango);
    queue_req(skt_pkg::REQ_INSERT, '0);
    queue_req(skt_pkg::REQ_INSERT, '1);
    queue_req(skt_pkg::REQ_INSERT, k_alpha);
    queue_req(skt_pkg::REQ_INSERT, k_b);
    queue_req(skt_pkg::REQ_INSERT, k_zeds);
    queue_req(skt_pkg::REQ_INSERT, '0);
    queue_req(skt_pkg::REQ_INSERT, '1);
    queue_req(skt_pkg::REQ_SEARCH, '0);
    queue_req(skt_pkg::REQ_SEARCH, '1);
    queue_req(skt_pkg::REQ_SEARCH, {"ALPHB", 16'h0000});
    queue_req(REQ_UNUSED, '1);
    queue_req(skt_pkg::REQ_DELETE, k_alpha);
    queue_req(skt_pkg::REQ_DELETE, '0);
    queue_req(skt_pkg::REQ_DELETE, '1);
    queue_req(skt_pkg::REQ_DELETE, k_mango);
    queue_req(skt_pkg::REQ_DELETE, k_b);
    queue_req(skt_pkg::REQ_DELETE, k_zeds);
    queue_req(skt_pkg::REQ_DELETE, k_zeds);

    for (i = 0; i < POOL_SIZE; i++) begin
      do begin
        k_tmp = (i % 2 == 0) ? name_key() : random_key();
      end while (used.exists(k_tmp));
      used[k_tmp] = 1'b1;
      key_pool[i] = k_tmp;
    end
    for (i = POOL_SIZE - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      k_tmp = key_pool[i];
      key_pool[i] = key_pool[j];
      key_pool[j] = k_tmp;
    end

    // The table is empty here, so these inserts fill it exactly.
    for (i = 0; i < TABLE_DEPTH; i++) queue_req(skt_pkg::REQ_INSERT, key_pool[i], i == 0);
    queue_req(skt_pkg::REQ_INSERT, key_pool[TABLE_DEPTH + 3]);
    queue_req(skt_pkg::REQ_INSERT, key_pool[5]);
    queue_req(skt_pkg::REQ_SEARCH, key_pool[TABLE_DEPTH - 1]);
    queue_req(skt_pkg::REQ_SEARCH, key_pool[TABLE_DEPTH + 8]);
    queue_req(REQ_UNUSED, key_pool[0]);

    made = 0;
    while (made < RANDOM_ITEMS) begin
      mode = $urandom_range(0, 2);
      len = $urandom_range(20, 60);
      for (j = 0; j < len && made < RANDOM_ITEMS; j++) begin
        r = $urandom_range(0, 99);
        case (mode)
          0: rq = (r < 70) ? skt_pkg::REQ_INSERT : (r < 85) ? skt_pkg::REQ_SEARCH :
                  (r < 97) ? skt_pkg::REQ_DELETE : REQ_UNUSED;
          1: rq = (r < 20) ? skt_pkg::REQ_INSERT : (r < 40) ? skt_pkg::REQ_SEARCH :
                  (r < 97) ? skt_pkg::REQ_DELETE : REQ_UNUSED;
          default: rq = (r < 35) ? skt_pkg::REQ_INSERT : (r < 65) ? skt_pkg::REQ_SEARCH :
                        (r < 96) ? skt_pkg::REQ_DELETE : REQ_UNUSED;
        endcase
        r = $urandom_range(0, 99);
        if (r < 85) begin
          k_tmp = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else if (r < 92) begin
          flip = skt_pkg::key_t'(1) << $urandom_range(0, skt_pkg::KEY_W - 1);
          k_tmp = key_pool[$urandom_range(0, POOL_SIZE - 1)] ^ flip;
        end else begin
          k_tmp = random_key();
        end
        queue_req(rq, k_tmp, j == 0 && $urandom_range(0, 3) == 0);
        made++;
      end
    end
  endtask

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d responses outstanding", cycle_cnt,
               pending_rsp.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.req_type <= skt_pkg::REQ_INSERT;
      req_ch.key <= '0;
      send_wait <= 0;
    end else begin
      send_gap = send_wait;
      if (req_ch.valid && req_ch.ready) begin
        pending_rsp.push_back(apply_request(cur_req.rq, cur_req.key));
        req_seen[cur_req.rq]++;
        status_seen[pending_rsp[$].status]++;
        req_in_flight = 1'b0;
        if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
        send_gap = draw_gap(send_burst);
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (send_gap > 0) begin
          req_ch.valid <= 1'b0;
          send_wait <= send_gap - 1;
        end else if (pending_req.size() > 0 &&
                     (!pending_req[0].drain_first || pending_rsp.size() == 0)) begin
          cur_req = pending_req.pop_front();
          if (cur_req.drain_first) sender_pauses++;
          req_in_flight = 1'b1;
          req_ch.valid <= 1'b1;
          req_ch.req_type <= cur_req.rq;
          req_ch.key <= cur_req.key;
          send_wait <= 0;
        end else begin
          req_ch.valid <= 1'b0;
          send_wait <= 0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      recv_wait <= 0;
    end else begin
      recv_gap = recv_wait;
      if (rsp_ch.valid && rsp_ch.ready) begin
        rsp_seen++;
        if (pending_rsp.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("Unexpected response transaction: status %0d position %0d count %0d",
                     rsp_ch.status, rsp_ch.position, rsp_ch.entry_count);
        end else begin
          want = pending_rsp.pop_front();
          if (rsp_ch.status !== want.status || rsp_ch.position !== want.position ||
              rsp_ch.entry_count !== want.entry_count) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("Response %0d mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                       rsp_seen, want.status, want.position, want.entry_count,
                       rsp_ch.status, rsp_ch.position, rsp_ch.entry_count);
          end
        end
        // A long hold lets requests back up until the block stalls its input.
        if (rsp_seen % 200 == 100) begin
          recv_gap = LONG_HOLD;
          long_holds++;
        end else begin
          if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
          recv_gap = draw_gap(recv_burst);
        end
      end
      if (recv_gap > 0) begin
        rsp_ch.ready <= 1'b0;
        recv_wait <= recv_gap - 1;
      end else begin
        rsp_ch.ready <= 1'b1;
        recv_wait <= 0;
      end
    end
  end

  initial begin
    build_stimulus();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    while (pending_req.size() != 0 || req_in_flight || pending_rsp.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    errors += pending_rsp.size();
    $display("Covered %0d requests: %0d insert, %0d search, %0d delete, %0d unused type;",
             req_seen[0] + req_seen[1] + req_seen[2] + req_seen[3],
             req_seen[skt_pkg::REQ_INSERT], req_seen[skt_pkg::REQ_SEARCH],
             req_seen[skt_pkg::REQ_DELETE], req_seen[REQ_UNUSED]);
    $display("outcomes %0d ok, %0d absent, %0d duplicate, %0d full; %0d long holds, %0d pauses.",
             status_seen[skt_pkg::ST_OK], status_seen[skt_pkg::ST_ABSENT],
             status_seen[skt_pkg::ST_DUP], status_seen[skt_pkg::ST_FULL],
             long_holds, sender_pauses);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* sorted_key_table.f */
rtl/skt_pkg.sv
rtl/skt_if.sv
rtl/skt_key_ram.sv
rtl/sorted_key_table.sv
tb/sorted_key_table_tb.sv
